// ===== hw/rtl/dtfp_pkg.sv =====
// shared types, constants and the temperature decode function of the frame parser
`timescale 1ns / 1ps

package dtfp_pkg;

   localparam int FRAME_BYTES    = 10;
   localparam int COUNT_W        = 4;
   localparam int BYTE_W         = 8;
   localparam int FIELD_W        = 16;
   localparam int RSP_DATA_W     = 5 * FIELD_W;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [COUNT_W-1:0] COUNT_FULL     = COUNT_W'(FRAME_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_OVERFLOW = COUNT_W'(FRAME_BYTES + 1);

   localparam logic [BYTE_W-1:0] FRAME_OPEN_RESET    = 8'd2;
   localparam logic [BYTE_W-1:0] FRAME_CLOSE_RESET   = 8'd3;
   localparam logic [BYTE_W-1:0] DIGIT_PADDING_RESET = 8'd0;

   localparam logic signed [FIELD_W-1:0] TEMP_SCALE = 16'sd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_OPEN    = 2'd0,
      CSR_FRAME_CLOSE   = 2'd1,
      CSR_DIGIT_PADDING = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_open;
      logic [BYTE_W-1:0] frame_close;
      logic [BYTE_W-1:0] digit_padding;
   } cfg_type;

   typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_type;

   // (int - pad) * 100 + (frac - pad) in signed hundredths
   function automatic logic signed [FIELD_W-1:0] temp_decode(
      input logic [BYTE_W-1:0] int_byte,
      input logic [BYTE_W-1:0] frac_byte,
      input logic [BYTE_W-1:0] pad
   );
      logic signed [BYTE_W:0]    whole;
      logic signed [BYTE_W:0]    frac;
      logic signed [FIELD_W-1:0] scaled;
      whole  = $signed({1'b0, int_byte}) - $signed({1'b0, pad});
      frac   = $signed({1'b0, frac_byte}) - $signed({1'b0, pad});
      scaled = FIELD_W'(whole) * TEMP_SCALE;
      return scaled + FIELD_W'(frac);
   endfunction

endpackage

// ===== hw/rtl/dtfp_frame_store.sv =====
// byte counter and frame byte store, with start and end token detection
`timescale 1ns / 1ps

module dtfp_frame_store (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   input  dtfp_pkg::cfg_type       cfg,
   output logic                    emit,
   output dtfp_pkg::frame_type     frame
);
   import dtfp_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   frame_type          store_ff;
   logic               is_start;
   logic               is_end;
   logic               store_wr;

   assign is_start = (rx_byte == cfg.frame_open);
   assign is_end   = !is_start && (rx_byte == cfg.frame_close);
   assign store_wr = accept && !is_start && !is_end && (count_ff < COUNT_FULL);
   assign emit     = accept && is_end && (count_ff == COUNT_FULL);
   assign frame    = store_ff;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         priority if (is_start) begin
            count_in = '0;
         end else if (is_end) begin
            count_in = count_ff;
         end else if (count_ff < COUNT_FULL) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            count_in = COUNT_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (store_wr && (count_ff == COUNT_W'(i))) begin
            store_ff[i] <= rx_byte;
         end
      end
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_OVERFLOW)
      else $error("byte count beyond overflow value");

   a_start_clears : assert property (@(posedge clock) disable iff (reset)
      accept && is_start |=> count_ff == '0)
      else $error("start token did not clear count");

   a_store_advances : assert property (@(posedge clock) disable iff (reset)
      store_wr |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("count did not advance on stored byte");

   a_end_keeps_count : assert property (@(posedge clock) disable iff (reset)
      accept && is_end |=> count_ff == $past(count_ff))
      else $error("end token changed count");

endmodule

// ===== hw/rtl/dtfp_decode.sv =====
// frame field decode and result register with its handshake
`timescale 1ns / 1ps

module dtfp_decode (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  emit,
   input  dtfp_pkg::frame_type                   frame,
   input  logic [7:0]                            digit_padding,
   output logic                                  slot_free,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dtfp_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import dtfp_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   logic [RSP_DATA_W-1:0]   data_ff;
   logic [RSP_DATA_W-1:0]   data_in;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      data_in[FIELD_W-1:0] = {frame[0], frame[1]};
      for (int k = 0; k < 4; k++) begin
         data_in[FIELD_W*(k+1) +: FIELD_W] =
            temp_decode(frame[2 + 2*k], frame[3 + 2*k], digit_padding);
      end
   end

   assign valid_in = emit || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   a_no_emit_when_full : assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("item emitted into occupied result register");

   a_emit_shows : assert property (@(posedge clock) disable iff (reset)
      emit |=> valid_ff)
      else $error("emitted item not presented");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_tready && !emit |=> !valid_ff)
      else $error("taken item presented again");

endmodule

// ===== hw/rtl/delimited_temp_frame_parser_core.sv =====
// top level of the delimited temperature frame parser
//
//  channel  | direction | payload (lowest bit up)
//  req_     | in        | tdata[7:0] rx_byte
//  rsp_     | out       | tdata mode_word, temp_current, temp_highest, temp_lowest, temp_mean
//  csr_     | in        | wr_en, index (0 start, 1 end, 2 padding), wdata[7:0]
//
// one byte per cycle unless stalled; a result shows the cycle after its end token is taken
// rate is set by the single result register: bytes stall only while it holds an untaken item
// synchronous active-high reset clears count and result valid, sets configuration to defaults
// frame store bytes are undefined until written
`timescale 1ns / 1ps

module delimited_temp_frame_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // mode_word, temp_current, temp_highest, temp_lowest, temp_mean
   output logic [dtfp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [dtfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_wdata
);
   import dtfp_pkg::*;

   cfg_type    cfg_ff;
   logic       accept;
   logic       emit;
   logic       slot_free;
   frame_type  frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_open    <= FRAME_OPEN_RESET;
         cfg_ff.frame_close   <= FRAME_CLOSE_RESET;
         cfg_ff.digit_padding <= DIGIT_PADDING_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_OPEN:    cfg_ff.frame_open    <= csr_wdata;
            CSR_FRAME_CLOSE:   cfg_ff.frame_close   <= csr_wdata;
            CSR_DIGIT_PADDING: cfg_ff.digit_padding <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = slot_free;
   assign accept     = req_tvalid && slot_free;

   dtfp_frame_store u_store (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .emit    (emit),
      .frame   (frame)
   );

   dtfp_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .frame         (frame),
      .digit_padding (cfg_ff.digit_padding),
      .slot_free     (slot_free),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
